[design/modexp_pkg.sv]
// shared constants for the modular exponentiation block
package modexp_pkg;

    localparam int unsigned DATA_W     = 32;
    localparam int unsigned CFG_ADDR_W = 3;

    // register select is the word index of the byte address
    localparam logic REG_MODULUS  = 1'b0;
    localparam logic REG_EXPONENT = 1'b1;

    localparam logic [DATA_W-1:0] RESET_MODULUS  = 32'd3233;
    localparam logic [DATA_W-1:0] RESET_EXPONENT = 32'd17;

endpackage

[design/modexp_mulmod.sv]
// bit-serial interleaved modular multiplier, one multiplier bit per cycle
module modexp_mulmod #(
    parameter int unsigned OPERAND_WIDTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_start,
    input  logic [OPERAND_WIDTH-1:0] i_a,
    input  logic [OPERAND_WIDTH-1:0] i_b,
    input  logic [OPERAND_WIDTH-1:0] i_m,
    output logic                     o_done,
    output logic [OPERAND_WIDTH-1:0] o_result
);

    localparam int unsigned W  = OPERAND_WIDTH;
    localparam int unsigned CW = $clog2(W);

    logic [W-1:0]  r_a;
    logic [W-1:0]  r_b;
    logic [W-1:0]  r_m;
    logic [W-1:0]  r_acc;
    logic [CW-1:0] r_cnt;
    logic          r_busy;
    logic          r_done;

    logic [W+1:0]  t_sum;
    logic [W+2:0]  t_d1;
    logic [W+2:0]  t_d2;
    logic [W-1:0]  n_acc;

    // acc stays below m; 2*acc + b is below 3m, so at most two subtractions
    always_comb begin
        t_sum = {1'b0, r_acc, 1'b0} + (r_a[W-1] ? {2'b00, r_b} : {(W+2){1'b0}});
        t_d1  = {1'b0, t_sum} - {3'b000, r_m};
        t_d2  = {1'b0, t_sum} - {2'b00, r_m, 1'b0};
        if (!t_d2[W+2]) begin
            n_acc = t_d2[W-1:0];
        end else if (!t_d1[W+2]) begin
            n_acc = t_d1[W-1:0];
        end else begin
            n_acc = t_sum[W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_done <= 1'b0;
        end else if (r_busy) begin
            if (r_cnt == '0) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end else begin
            r_done <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_a   <= i_a;
            r_b   <= i_b;
            r_m   <= i_m;
            r_acc <= '0;
            r_cnt <= CW'(W - 1);
        end else if (r_busy) begin
            r_acc <= n_acc;
            r_a   <= {r_a[W-2:0], 1'b0};
            r_cnt <= r_cnt - 1'b1;
        end
    end

    assign o_done   = r_done;
    assign o_result = r_acc;

endmodule

[design/modular_exponentiation_top.sv]
// modular exponentiation by right-to-left square-and-multiply
// steps: the base reduction, then per exponent bit a square and, if set, a multiply,
//   stopping after the highest set bit: at most 2*OPERAND_WIDTH multiplies
// zero exponent or modulus below two: no multiply, the result goes straight to S_DONE
// throughput: one item at a time; a new base is taken while the previous result waits
// reset: synchronous active low, registers return to modulus 3233 and exponent 17
module modular_exponentiation_top #(
    parameter int unsigned OPERAND_WIDTH = 32
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    // input channel
    input  logic                                  i_in_valid,
    output logic                                  o_in_stall,
    input  logic [modexp_pkg::DATA_W-1:0]         i_base_value,
    // output channel
    output logic                                  o_out_valid,
    input  logic                                  i_out_stall,
    output logic [modexp_pkg::DATA_W-1:0]         o_power_result,
    // configuration port
    input  logic                                  psel,
    input  logic                                  penable,
    input  logic                                  pwrite,
    input  logic [modexp_pkg::CFG_ADDR_W-1:0]     paddr,
    input  logic [modexp_pkg::DATA_W-1:0]         pwdata,
    output logic [modexp_pkg::DATA_W-1:0]         prdata,
    output logic                                  pready
);

    localparam int unsigned W = OPERAND_WIDTH;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_RED  = 3'd1;
    localparam logic [2:0] S_DISP = 3'd2;
    localparam logic [2:0] S_MUL  = 3'd3;
    localparam logic [2:0] S_SQR  = 3'd4;
    localparam logic [2:0] S_DONE = 3'd5;

    logic [modexp_pkg::DATA_W-1:0] r_modulus;
    logic [modexp_pkg::DATA_W-1:0] r_exponent;

    logic [2:0]   r_state;
    logic [W-1:0] r_e;
    logic [W-1:0] r_acc;
    logic [W-1:0] r_b;
    logic [W-1:0] r_res;
    logic         r_mul_done;
    logic         r_out_valid;
    logic [W-1:0] r_out;

    logic         t_in_acc;
    logic         t_out_load;
    logic [W-1:0] t_mod;
    logic [W-1:0] t_exp;
    logic         t_trivial;
    logic         mm_start;
    logic [W-1:0] mm_a;
    logic [W-1:0] mm_b;
    logic         mm_done;
    logic [W-1:0] mm_res;

    // configuration registers
    assign pready = 1'b1;
    assign prdata = (paddr[2] == modexp_pkg::REG_EXPONENT) ? r_exponent : r_modulus;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_modulus  <= modexp_pkg::RESET_MODULUS;
            r_exponent <= modexp_pkg::RESET_EXPONENT;
        end else if (psel && penable && pwrite && pready) begin
            unique case (paddr[2])
                modexp_pkg::REG_MODULUS:  r_modulus  <= pwdata;
                modexp_pkg::REG_EXPONENT: r_exponent <= pwdata;
                default:                  r_modulus  <= r_modulus;
            endcase
        end
    end

    assign t_mod     = r_modulus[W-1:0];
    assign t_exp     = r_exponent[W-1:0];
    // zero exponent gives one; modulus of zero or one gives zero
    assign t_trivial = (t_exp == '0) || (t_mod[W-1:1] == '0);

    assign o_in_stall = (r_state != S_IDLE);
    assign t_in_acc   = i_in_valid && !o_in_stall;
    assign t_out_load = (r_state == S_DONE) && (!r_out_valid || !i_out_stall);

    // multiplier requests
    always_comb begin
        mm_start = 1'b0;
        mm_a     = r_b;
        mm_b     = r_b;
        if (r_state == S_IDLE) begin
            mm_start = t_in_acc && !t_trivial;
            mm_a     = i_base_value[W-1:0];
            mm_b     = W'(1);
        end else if (r_state == S_DISP) begin
            mm_start = (r_e != '0);
            if (r_e[0] && !r_mul_done) begin
                mm_a = r_acc;
            end
        end
    end

    modexp_mulmod #(
        .OPERAND_WIDTH(W)
    ) u_mulmod (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (mm_start),
        .i_a      (mm_a),
        .i_b      (mm_b),
        .i_m      (t_mod),
        .o_done   (mm_done),
        .o_result (mm_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (t_in_acc) begin
                        r_e <= t_exp;
                        if (t_exp == '0) begin
                            r_res   <= W'(1);
                            r_state <= S_DONE;
                        end else if (t_trivial) begin
                            r_res   <= '0;
                            r_state <= S_DONE;
                        end else begin
                            r_state <= S_RED;
                        end
                    end
                end
                S_RED: begin
                    if (mm_done) begin
                        r_b        <= mm_res;
                        r_acc      <= W'(1);
                        r_mul_done <= 1'b0;
                        r_state    <= S_DISP;
                    end
                end
                S_DISP: begin
                    if (r_e == '0) begin
                        r_res   <= r_acc;
                        r_state <= S_DONE;
                    end else if (r_e[0] && !r_mul_done) begin
                        r_state <= S_MUL;
                    end else begin
                        r_state <= S_SQR;
                    end
                end
                S_MUL: begin
                    if (mm_done) begin
                        r_acc      <= mm_res;
                        r_mul_done <= 1'b1;
                        // no higher bits left: skip the final square
                        if (r_e[W-1:1] == '0) begin
                            r_e <= '0;
                        end
                        r_state <= S_DISP;
                    end
                end
                S_SQR: begin
                    if (mm_done) begin
                        r_b        <= mm_res;
                        r_e        <= {1'b0, r_e[W-1:1]};
                        r_mul_done <= 1'b0;
                        r_state    <= S_DISP;
                    end
                end
                S_DONE: begin
                    if (t_out_load) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // output register holds a beat until it is taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (t_out_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (t_out_load) begin
            r_out <= r_res;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_power_result = modexp_pkg::DATA_W'(r_out);

endmodule

[test/tb_modular_exponentiation_top.sv]
// self-checking testbench for the modular exponentiation block
`timescale 1ns / 100ps

module tb_modular_exponentiation_top;

    localparam int unsigned DATA_W       = modexp_pkg::DATA_W;
    localparam int unsigned CFG_ADDR_W   = modexp_pkg::CFG_ADDR_W;
    localparam int unsigned OPERAND_W    = 32;
    localparam int unsigned TARGET_ITEMS = 270;
    // worst case is one reduction plus a square and multiply per exponent bit
    localparam int unsigned DRAIN_CYCLES = 2300;

    typedef struct packed {
        logic [DATA_W-1:0] modulus;
        logic [DATA_W-1:0] exponent;
        logic [DATA_W-1:0] base;
        logic              known;
        logic [DATA_W-1:0] power;
    } t_power_case;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  i_in_valid;
    logic                  o_in_stall;
    logic [DATA_W-1:0]     i_base_value;
    logic                  o_out_valid;
    logic                  i_out_stall;
    logic [DATA_W-1:0]     o_power_result;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [CFG_ADDR_W-1:0] paddr;
    logic [DATA_W-1:0]     pwdata;
    logic [DATA_W-1:0]     prdata;
    logic                  pready;

    logic [DATA_W-1:0]     pending_powers[$];
    t_power_case           directed_cases[$];
    logic [DATA_W-1:0]     cur_modulus  = modexp_pkg::RESET_MODULUS;
    logic [DATA_W-1:0]     cur_exponent = modexp_pkg::RESET_EXPONENT;
    logic [DATA_W-1:0]     oldest_power;
    int unsigned           mismatch_count = 0;
    int unsigned           bases_sent = 0;

    modular_exponentiation_top #(
        .OPERAND_WIDTH(OPERAND_W)
    ) i_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_base_value   (i_base_value),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_power_result (o_power_result),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready)
    );

    always #4 i_clk = ~i_clk;

    // right-to-left square-and-multiply with 64-bit products
    function automatic logic [DATA_W-1:0] predict_power(input logic [DATA_W-1:0] b,
                                                        input logic [DATA_W-1:0] e,
                                                        input logic [DATA_W-1:0] m);
        logic [63:0] acc;
        logic [63:0] sq;
        logic [63:0] m64;
        int          k;
        acc = 64'd1;
        sq  = {32'd0, b};
        m64 = {32'd0, m};
        if (e == '0) return 32'd1;
        if (m == '0) return 32'd0;
        for (k = 0; k < OPERAND_W; k++) begin
            if (e[k]) acc = (acc * sq) % m64;
            sq = (sq * sq) % m64;
        end
        return acc[DATA_W-1:0];
    endfunction

    function automatic int unsigned idle_len();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 75) return $urandom_range(1, 3);
        if (r < 95) return $urandom_range(4, 12);
        return $urandom_range(40, 200);
    endfunction

    task automatic flag_mismatch(input string what, input logic [DATA_W-1:0] got,
                                 input logic [DATA_W-1:0] want);
        $display("mismatch %0d: %s got %h want %h at %0t",
                 mismatch_count, what, got, want, $realtime);
        mismatch_count++;
    endtask

    task automatic add_case(input logic [DATA_W-1:0] m, input logic [DATA_W-1:0] e,
                            input logic [DATA_W-1:0] b, input logic known,
                            input logic [DATA_W-1:0] r);
        directed_cases.push_back({m, e, b, known, r});
    endtask

    task automatic drain_results();
        while (pending_powers.size() != 0) @(posedge i_clk);
    endtask

    task automatic cfg_write(input logic sel, input logic [DATA_W-1:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {sel, 2'b00};
        pwdata  <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (sel == modexp_pkg::REG_MODULUS) cur_modulus = val;
        else cur_exponent = val;
    endtask

    // key changes only once the block has gone idle
    task automatic set_key(input logic [DATA_W-1:0] m, input logic [DATA_W-1:0] e);
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        drain_results();
        cfg_write(modexp_pkg::REG_MODULUS, m);
        cfg_write(modexp_pkg::REG_EXPONENT, e);
    endtask

    task automatic send_base(input logic [DATA_W-1:0] b, input logic [DATA_W-1:0] want);
        i_in_valid   <= 1'b1;
        i_base_value <= b;
        do @(posedge i_clk); while (o_in_stall);
        pending_powers.push_back(want);
        bases_sent++;
    endtask

    task automatic sender_gap(input bit quiet);
        int unsigned g;
        g = 0;
        if (!quiet) begin
            if ($urandom_range(0, 24) == 0) begin
                // hold off until the block has handed back everything
                i_in_valid <= 1'b0;
                @(posedge i_clk);
                drain_results();
            end else begin
                if ($urandom_range(0, 2) != 0) g = idle_len();
                if (g > 0) begin
                    i_in_valid <= 1'b0;
                    repeat (g) @(posedge i_clk);
                end
            end
        end
    endtask

    // result beats against the oldest expectation
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_powers.size() == 0) begin
                flag_mismatch("result beat with nothing pending", o_power_result, '0);
            end else begin
                oldest_power = pending_powers.pop_front();
                if (o_power_result !== oldest_power)
                    flag_mismatch("power_result", o_power_result, oldest_power);
            end
        end
    end

    // receiver back-pressure: runs of readiness broken by stalls
    initial begin
        i_out_stall <= 1'b0;
        while (i_rst_n !== 1'b1) @(posedge i_clk);
        forever begin
            i_out_stall <= 1'b0;
            if ($urandom_range(0, 9) < 4) repeat ($urandom_range(50, 400)) @(posedge i_clk);
            else repeat ($urandom_range(1, 10)) @(posedge i_clk);
            i_out_stall <= 1'b1;
            repeat (idle_len()) @(posedge i_clk);
        end
    end

    initial begin
        t_power_case       pc;
        logic [DATA_W-1:0] m;
        logic [DATA_W-1:0] e;
        logic [DATA_W-1:0] b;
        int unsigned       r;
        int unsigned       phase_len;
        int unsigned       n;
        bit                quiet;

        i_rst_n      <= 1'b0;
        i_in_valid   <= 1'b0;
        i_base_value <= '0;
        psel         <= 1'b0;
        penable      <= 1'b0;
        pwrite       <= 1'b0;
        paddr        <= '0;
        pwdata       <= '0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // first rows run on the key left by reset
        add_case(32'd3233, 32'd17, 32'd65, 1'b1, 32'd2790);
        add_case(32'd3233, 32'd17, 32'd0, 1'b1, 32'd0);
        add_case(32'd3233, 32'd17, 32'd1, 1'b1, 32'd1);
        add_case(32'd3233, 32'd17, 32'd3233, 1'b1, 32'd0);
        add_case(32'd3233, 32'd17, 32'hFFFF_FFFF, 1'b0, '0);
        add_case(32'd3233, 32'd2753, 32'd2790, 1'b0, '0);
        add_case(32'd3233, 32'd0, 32'd12345, 1'b1, 32'd1);
        add_case(32'd3233, 32'd0, 32'hFFFF_FFFF, 1'b1, 32'd1);
        // zero exponent wins over any modulus; otherwise a modulus of zero or one gives zero
        add_case(32'd0, 32'd0, 32'd7, 1'b1, 32'd1);
        add_case(32'd0, 32'd5, 32'd7, 1'b1, 32'd0);
        add_case(32'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 32'd0);
        add_case(32'd1, 32'd0, 32'd9, 1'b1, 32'd1);
        add_case(32'd1, 32'd5, 32'd7, 1'b1, 32'd0);
        add_case(32'd2, 32'd1, 32'd0, 1'b1, 32'd0);
        add_case(32'd2, 32'd3, 32'hFFFF_FFFF, 1'b1, 32'd1);
        add_case(32'd1000, 32'd1, 32'd999, 1'b1, 32'd999);
        // large moduli, with bases up to the modulus
        add_case(32'h8000_0000, 32'd2, 32'h0001_0000, 1'b1, 32'd0);
        add_case(32'hFFFF_FFFF, 32'd2, 32'hFFFF_FFFE, 1'b1, 32'd1);
        add_case(32'hFFFF_FFFF, 32'd1, 32'hFFFF_FFFF, 1'b1, 32'd0);
        add_case(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFE, 1'b0, '0);
        add_case(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd0, 1'b1, 32'd0);
        add_case(32'hFFFF_FFFB, 32'h8000_0000, 32'd3, 1'b0, '0);

        foreach (directed_cases[i]) begin
            pc = directed_cases[i];
            if (pc.modulus != cur_modulus || pc.exponent != cur_exponent)
                set_key(pc.modulus, pc.exponent);
            send_base(pc.base, pc.known ? pc.power
                                        : predict_power(pc.base, cur_exponent, cur_modulus));
            sender_gap(1'b0);
        end

        while (bases_sent < TARGET_ITEMS) begin
            r = $urandom_range(0, 99);
            if (r < 60) m = $urandom();
            else if (r < 80) m = $urandom_range(2, 5000);
            else if (r < 88) m = 32'hFFFF_FFFF;
            else if (r < 93) m = 32'd1;
            else if (r < 97) m = 32'd0;
            else m = 32'd2;

            // long exponents are slow, so they get short phases
            r = $urandom_range(0, 99);
            phase_len = $urandom_range(6, 20);
            if (r < 55) e = $urandom_range(1, 255);
            else if (r < 75) e = $urandom_range(256, 65535);
            else if (r < 85) begin
                e = $urandom();
                phase_len = $urandom_range(2, 4);
            end else if (r < 92) e = 32'd0;
            else e = 32'd1;

            set_key(m, e);
            quiet = ($urandom_range(0, 3) == 0);
            for (n = 0; n < phase_len; n++) begin
                r = $urandom_range(0, 99);
                if (r < 70) b = $urandom();
                else if (r < 80) b = (m > 32'd1) ? ($urandom() % m) : $urandom();
                else if (r < 85) b = 32'd0;
                else if (r < 90) b = 32'd1;
                else if (r < 95) b = m - 32'd1;
                else b = 32'hFFFF_FFFF;
                send_base(b, predict_power(b, cur_exponent, cur_modulus));
                sender_gap(quiet);
            end
        end

        i_in_valid <= 1'b0;
        @(posedge i_clk);
        drain_results();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("modular_exponentiation_top regression: pass");
        end else begin
            $display("modular_exponentiation_top regression: fail");
        end
        $finish;
    end

    // about five times the slowest legal run
    initial begin
        #30_000_000;
        $display("modular_exponentiation_top regression: fail");
        $finish;
    end

endmodule

[modular_exponentiation_top.f]
design/modexp_pkg.sv
design/modexp_mulmod.sv
design/modular_exponentiation_top.sv
test/tb_modular_exponentiation_top.sv
